// ===== sv/wildcard_signature_prefix_matcher_unit_assert.svh =====
// Assertion macros for the signature matcher top level.
// Expect clk and arst_n in the scope of each use.
`ifndef WILDCARD_SIGNATURE_PREFIX_MATCHER_UNIT_ASSERT_SVH
`define WILDCARD_SIGNATURE_PREFIX_MATCHER_UNIT_ASSERT_SVH

// checked only out of reset
`define WSPM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define WSPM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/wspm_pkg.sv =====
// Package for the wildcard signature prefix matcher.
// Holds opcodes, field widths and parameter defaults; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wspm_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int MAXLEN_DEF  = 16;

	localparam int OPCODE_W = 2;
	localparam int INDEX_W  = 4;
	localparam int POSN_W   = 4;
	localparam int BYTE_W   = 8;
	localparam int LENGTH_W = 5;
	localparam int WORD_W   = BYTE_W + 1;

	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = OPCODE_W;
	localparam int M_TDATA_W = 16;

	localparam logic [OPCODE_W-1:0] OP_PATTERN = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_LENGTH  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_BYTE    = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_START   = 2'd3;

endpackage

`default_nettype wire

// ===== sv/wildcard_signature_prefix_matcher_unit.sv =====
// Top level of the wildcard signature prefix matcher.
// Depends on wspm_pkg, wspm_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "wildcard_signature_prefix_matcher_unit_assert.svh"

// One result transaction per input transaction, in order. Items enter at one per
// cycle unless a result held by m_tready stalls them. Each item passes an input
// register, then the table update and longest-match selection into the result
// register. Each entry's pattern sits in its own RAM, read one position ahead of
// the file byte counter so that all entries compare the incoming byte at once.
// No clearing pass is needed after reset: pattern bytes must be written before an
// entry of that length is used.
module wildcard_signature_prefix_matcher_unit #(
	parameter int ENTRIES = wspm_pkg::ENTRIES_DEF,
	parameter int MAXLEN  = wspm_pkg::MAXLEN_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// entry_index[3:0], position[7:4], byte_value[15:8], is_wildcard[16],
	// entry_length[21:17], zero fill
	input  wire logic [wspm_pkg::S_TDATA_W-1:0] s_tdata,
	// opcode[1:0]
	input  wire logic [wspm_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// found[0], best_entry[4:1], best_length[9:5], bytes_seen[14:10], zero fill
	output logic      [wspm_pkg::M_TDATA_W-1:0] m_tdata
);

	import wspm_pkg::*;

	localparam int CNT_W = $clog2(MAXLEN + 1);
	localparam int POS_W = (MAXLEN > 1) ? $clog2(MAXLEN) : 1;

	logic                valid_s1;
	logic [OPCODE_W-1:0] op_s1;
	logic [INDEX_W-1:0]  idx_s1;
	logic [POSN_W-1:0]   pos_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                wild_s1;
	logic [LENGTH_W-1:0] len_s1;

	logic [CNT_W-1:0]    len_q [ENTRIES];
	logic [ENTRIES-1:0]  alive_q;
	logic [CNT_W-1:0]    cnt_q;

	logic                m_valid_q;
	logic                found_q;
	logic [INDEX_W-1:0]  best_entry_q;
	logic [LENGTH_W-1:0] best_len_q;
	logic [LENGTH_W-1:0] bytes_q;

	logic                s_accept;
	logic                adv;
	logic [CNT_W-1:0]    len_nx [ENTRIES];
	logic [ENTRIES-1:0]  alive_nx;
	logic [CNT_W-1:0]    cnt_nx;
	logic [POS_W-1:0]    rd_addr;
	logic [WORD_W-1:0]   rd_word [ENTRIES];
	logic [ENTRIES-1:0]  matched;
	logic [ENTRIES-1:0]  win;
	logic                found_c;
	logic [INDEX_W-1:0]  best_entry_c;
	logic [LENGTH_W-1:0] best_len_c;
	logic                pos_ok;

	assign adv      = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign s_accept = s_tvalid && s_tready;
	assign pos_ok   = int'(pos_s1) < MAXLEN;
	assign rd_addr  = adv ? cnt_nx[POS_W-1:0] : cnt_q[POS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_s1   <= s_tuser[OPCODE_W-1:0];
			idx_s1  <= s_tdata[3:0];
			pos_s1  <= s_tdata[7:4];
			byte_s1 <= s_tdata[15:8];
			wild_s1 <= s_tdata[16];
			len_s1  <= s_tdata[21:17];
		end
	end

	for (genvar e = 0; e < ENTRIES; e++) begin : g_entry
		logic we;

		assign we = adv && (op_s1 == OP_PATTERN) && (int'(idx_s1) == e) && pos_ok;

		wspm_ram #(
			.WIDTH(WORD_W),
			.DEPTH(MAXLEN)
		) u_ram (
			.clk  (clk),
			.we   (we),
			.waddr(pos_s1[POS_W-1:0]),
			.wdata({wild_s1, byte_s1}),
			.raddr(rd_addr),
			.rdata(rd_word[e])
		);
	end

	// state after the item in stage one
	always_comb begin
		for (int e = 0; e < ENTRIES; e++) begin
			len_nx[e] = len_q[e];
		end
		alive_nx = alive_q;
		cnt_nx   = cnt_q;
		unique case (op_s1)
			OP_PATTERN: begin
			end
			OP_LENGTH: begin
				for (int e = 0; e < ENTRIES; e++) begin
					if (int'(idx_s1) == e) begin
						len_nx[e] = (int'(len_s1) > MAXLEN) ? CNT_W'(MAXLEN) : CNT_W'(len_s1);
					end
				end
			end
			OP_BYTE: begin
				if (cnt_q < CNT_W'(MAXLEN)) begin
					for (int e = 0; e < ENTRIES; e++) begin
						if ((cnt_q < len_q[e]) && !rd_word[e][BYTE_W] &&
						    (rd_word[e][BYTE_W-1:0] != byte_s1)) begin
							alive_nx[e] = 1'b0;
						end
					end
					cnt_nx = CNT_W'(cnt_q + 1'b1);
				end
			end
			OP_START: begin
				alive_nx = '1;
				cnt_nx   = '0;
			end
			default: begin
			end
		endcase
	end

	// longest full match, lowest index on a tie
	always_comb begin
		logic beaten;
		for (int e = 0; e < ENTRIES; e++) begin
			matched[e] = (len_nx[e] != '0) && alive_nx[e] && (len_nx[e] <= cnt_nx);
		end
		for (int e = 0; e < ENTRIES; e++) begin
			beaten = 1'b0;
			for (int j = 0; j < ENTRIES; j++) begin
				if (matched[j] && (j < e) && (len_nx[j] >= len_nx[e])) begin
					beaten = 1'b1;
				end
				if (matched[j] && (j > e) && (len_nx[j] > len_nx[e])) begin
					beaten = 1'b1;
				end
			end
			win[e] = matched[e] && !beaten;
		end
		found_c      = |matched;
		best_entry_c = '0;
		best_len_c   = '0;
		for (int e = 0; e < ENTRIES; e++) begin
			if (win[e]) begin
				best_entry_c = best_entry_c | INDEX_W'(e);
				best_len_c   = best_len_c | LENGTH_W'(len_nx[e]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < ENTRIES; e++) begin
				len_q[e] <= '0;
			end
			alive_q   <= '1;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				for (int e = 0; e < ENTRIES; e++) begin
					len_q[e] <= len_nx[e];
				end
				alive_q <= alive_nx;
				cnt_q   <= cnt_nx;
			end
			if (adv) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			found_q      <= found_c;
			best_entry_q <= best_entry_c;
			best_len_q   <= best_len_c;
			bytes_q      <= LENGTH_W'(cnt_nx);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, bytes_q, best_len_q, best_entry_q, found_q};

	`WSPM_ASSERT_ALWAYS(a_idle_after_reset, (!arst_n |=> !m_tvalid), "result offered straight after reset")
	`WSPM_ASSERT(a_cnt_bound, (cnt_q <= CNT_W'(MAXLEN)), "byte counter beyond maximum length")
	`WSPM_ASSERT(a_start_clears, (adv && (op_s1 == OP_START)) |=> ((cnt_q == '0) && (alive_q == '1)), "start did not reset file state")
	`WSPM_ASSERT(a_len_le_seen, m_valid_q |-> (best_len_q <= bytes_q), "best length exceeds bytes seen")
	`WSPM_ASSERT(a_found_len, m_valid_q |-> (found_q == (best_len_q != '0)), "found flag disagrees with length")

endmodule

`default_nettype wire

// ===== sv/wspm_ram.sv =====
// Generic single-write, single-read RAM with registered, write-first read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wspm_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire
